>>> hw/rtl/script_source_lexer_core_assert.svh
// Assertion macros for the lexer core; define NO_ASSERTIONS to drop them.
`ifndef SCRIPT_SOURCE_LEXER_CORE_ASSERT_SVH
`define SCRIPT_SOURCE_LEXER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSL_ASSERT(label, prop, msg)
`define SSL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hw/rtl/ssl_pkg.sv
package ssl_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned IDX_W       = 2;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_ESCAPE  = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_SKIP    = 3'd4;

  localparam logic [2:0] KIND_BYTE          = 3'd0;
  localparam logic [2:0] KIND_TOKEN_END     = 3'd1;
  localparam logic [2:0] KIND_LINE_END      = 3'd2;
  localparam logic [2:0] KIND_UNTERM_STRING = 3'd3;
  localparam logic [2:0] KIND_UNTERM_ESCAPE = 3'd4;
  localparam logic [2:0] KIND_DONE          = 3'd5;

  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd39;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_N      = 8'd110;
  localparam logic [7:0] CH_B      = 8'd98;
  localparam logic [7:0] CH_T      = 8'd116;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;

  localparam logic [2:0] MAX_COUNT = 3'(MAX_RESULTS);

  // All results caused by one source byte.
  typedef struct packed {
    logic [2:0]                   count;
    logic [MAX_RESULTS-1:0][2:0]  kind;
    logic [MAX_RESULTS-1:0][7:0]  value;
  } bundle_t;

endpackage

>>> hw/rtl/ssl_if.sv
interface ssl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_in;
  logic       end_of_source;

  modport source (output valid, code_in, end_of_source, input ready);
  modport sink (input valid, code_in, end_of_source, output ready);
endinterface

interface ssl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value_out;
  logic       run_end;

  modport source (output valid, kind, value_out, run_end, input ready);
  modport sink (input valid, kind, value_out, run_end, output ready);
endinterface

>>> hw/rtl/ssl_front.sv
module ssl_front (
  input  logic             clk,
  input  logic             rst,
  ssl_in_if.sink           src,
  output logic             push_valid,
  input  logic             push_ready,
  output ssl_pkg::bundle_t push_data
);

  logic [2:0] lex_mode, lex_mode_next;
  logic       token_open, token_open_next;
  logic       line_open, line_open_next;

  logic [2:0] n;
  logic       finish;
  logic [ssl_pkg::MAX_RESULTS-1:0][2:0] kk;
  logic [ssl_pkg::MAX_RESULTS-1:0][7:0] vv;
  logic [7:0] c;
  logic       last;
  logic       accept;

  assign c      = src.code_in;
  assign last   = src.end_of_source;
  assign accept = src.valid & src.ready;

  always_comb begin
    n               = 3'd0;
    kk              = '0;
    vv              = '0;
    lex_mode_next   = lex_mode;
    token_open_next = token_open;
    line_open_next  = line_open;
    finish          = last;

    case (lex_mode)
      ssl_pkg::MODE_SKIP: begin
        finish = 1'b0;
      end
      ssl_pkg::MODE_STRING: begin
        if (c == ssl_pkg::CH_LF ||
            (last && c != ssl_pkg::CH_QUOTE && c != ssl_pkg::CH_BSLASH)) begin
          kk[n[1:0]] = ssl_pkg::KIND_UNTERM_STRING;
          n = n + 3'd1;
          finish = 1'b0;
          lex_mode_next = ssl_pkg::MODE_SKIP;
        end else if (c == ssl_pkg::CH_BSLASH) begin
          if (last) begin
            kk[n[1:0]] = ssl_pkg::KIND_UNTERM_ESCAPE;
            n = n + 3'd1;
            finish = 1'b0;
            lex_mode_next = ssl_pkg::MODE_SKIP;
          end else begin
            lex_mode_next = ssl_pkg::MODE_ESCAPE;
          end
        end else begin
          kk[n[1:0]] = ssl_pkg::KIND_BYTE;
          vv[n[1:0]] = c;
          n = n + 3'd1;
          token_open_next = 1'b1;
          if (c == ssl_pkg::CH_QUOTE) begin
            lex_mode_next = ssl_pkg::MODE_NORMAL;
          end
        end
      end
      ssl_pkg::MODE_ESCAPE: begin
        if (last) begin
          kk[n[1:0]] = ssl_pkg::KIND_UNTERM_STRING;
          n = n + 3'd1;
          finish = 1'b0;
          lex_mode_next = ssl_pkg::MODE_SKIP;
        end else begin
          token_open_next = 1'b1;
          lex_mode_next = ssl_pkg::MODE_STRING;
          kk[n[1:0]] = ssl_pkg::KIND_BYTE;
          if (c == ssl_pkg::CH_N) begin
            vv[n[1:0]] = ssl_pkg::CH_LF;
            n = n + 3'd1;
          end else if (c == ssl_pkg::CH_B) begin
            vv[n[1:0]] = ssl_pkg::CH_BS;
            n = n + 3'd1;
          end else if (c == ssl_pkg::CH_T) begin
            vv[n[1:0]] = ssl_pkg::CH_TAB;
            n = n + 3'd1;
          end else if (c == ssl_pkg::CH_QUOTE) begin
            vv[n[1:0]] = ssl_pkg::CH_QUOTE;
            n = n + 3'd1;
          end else begin
            // unknown escape: pass the backslash, then the character
            vv[n[1:0]] = ssl_pkg::CH_BSLASH;
            n = n + 3'd1;
            kk[n[1:0]] = ssl_pkg::KIND_BYTE;
            vv[n[1:0]] = c;
            n = n + 3'd1;
          end
        end
      end
      ssl_pkg::MODE_COMMENT: begin
        if (c == ssl_pkg::CH_LF) begin
          if (token_open_next) begin
            kk[n[1:0]] = ssl_pkg::KIND_TOKEN_END;
            n = n + 3'd1;
            token_open_next = 1'b0;
            line_open_next = 1'b1;
          end
          kk[n[1:0]] = ssl_pkg::KIND_LINE_END;
          n = n + 3'd1;
          line_open_next = 1'b0;
          lex_mode_next = ssl_pkg::MODE_NORMAL;
        end
      end
      default: begin
        lex_mode_next = ssl_pkg::MODE_NORMAL;
        if (c == ssl_pkg::CH_LF || c == ssl_pkg::CH_CR || c == ssl_pkg::CH_SPACE) begin
          if (token_open_next) begin
            kk[n[1:0]] = ssl_pkg::KIND_TOKEN_END;
            n = n + 3'd1;
            token_open_next = 1'b0;
            line_open_next = 1'b1;
          end
          if (c == ssl_pkg::CH_LF) begin
            kk[n[1:0]] = ssl_pkg::KIND_LINE_END;
            n = n + 3'd1;
            line_open_next = 1'b0;
          end
        end else if (c == ssl_pkg::CH_QUOTE) begin
          if (last) begin
            kk[n[1:0]] = ssl_pkg::KIND_UNTERM_STRING;
            n = n + 3'd1;
            finish = 1'b0;
            lex_mode_next = ssl_pkg::MODE_SKIP;
          end else begin
            kk[n[1:0]] = ssl_pkg::KIND_BYTE;
            vv[n[1:0]] = c;
            n = n + 3'd1;
            token_open_next = 1'b1;
            lex_mode_next = ssl_pkg::MODE_STRING;
          end
        end else if (c == ssl_pkg::CH_SLASH) begin
          lex_mode_next = ssl_pkg::MODE_COMMENT;
        end else begin
          kk[n[1:0]] = ssl_pkg::KIND_BYTE;
          vv[n[1:0]] = c;
          n = n + 3'd1;
          token_open_next = 1'b1;
        end
      end
    endcase

    // end of source: close the token, close a non-empty line, mark done
    if (finish) begin
      if (token_open_next) begin
        kk[n[1:0]] = ssl_pkg::KIND_TOKEN_END;
        n = n + 3'd1;
        line_open_next = 1'b1;
      end
      if (line_open_next) begin
        kk[n[1:0]] = ssl_pkg::KIND_LINE_END;
        n = n + 3'd1;
      end
      kk[n[1:0]] = ssl_pkg::KIND_DONE;
      n = n + 3'd1;
    end
    if (last) begin
      lex_mode_next   = ssl_pkg::MODE_NORMAL;
      token_open_next = 1'b0;
      line_open_next  = 1'b0;
    end
  end

  assign src.ready       = push_ready;
  assign push_valid      = src.valid & (n != 3'd0);
  assign push_data.count = n;
  assign push_data.kind  = kk;
  assign push_data.value = vv;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode   <= ssl_pkg::MODE_NORMAL;
      token_open <= 1'b0;
      line_open  <= 1'b0;
    end else if (accept) begin
      lex_mode   <= lex_mode_next;
      token_open <= token_open_next;
      line_open  <= line_open_next;
    end
  end

endmodule

>>> hw/rtl/ssl_fifo.sv
module ssl_fifo #(
  parameter int unsigned DEPTH = ssl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ssl_pkg::bundle_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ssl_pkg::bundle_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ssl_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/ssl_back.sv
module ssl_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  ssl_pkg::bundle_t pop_data,
  ssl_out_if.source        res
);

  logic [ssl_pkg::IDX_W-1:0] idx;
  logic                      last_res;

  assign last_res      = ((3'(idx) + 3'd1) == pop_data.count);
  assign res.valid     = pop_valid;
  assign res.kind      = pop_data.kind[idx];
  assign res.value_out = pop_data.value[idx];
  assign res.run_end   = last_res;
  // release the bundle once its last result transfers
  assign pop_ready     = res.ready & last_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop_valid && res.ready) begin
      idx <= last_res ? '0 : idx + ssl_pkg::IDX_W'(1);
    end
  end

endmodule

>>> hw/rtl/script_source_lexer_core.sv
// Streaming lexer: accepts one source byte per cycle whenever the result queue
// has room, and delivers that byte's 0 to 4 results (token bytes, token and line
// ends, errors, source done) one per cycle while the result channel is ready,
// with run_end on the last one. A byte's results are registered in the result
// queue and offered behind any results still waiting. Input is held back only
// when QUEUE_DEPTH bytes' worth of results are still waiting, so sustained input
// rate is one byte per cycle as long as the consumer takes on average at least
// as many results per cycle as the bytes produce; bytes with no result (comments,
// skipping) only use a queue slot if they produce output.
`include "script_source_lexer_core_assert.svh"

module script_source_lexer_core #(
  parameter int unsigned QUEUE_DEPTH = ssl_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  ssl_in_if.sink     src,
  ssl_out_if.source  res
);

  logic             push_valid;
  logic             push_ready;
  ssl_pkg::bundle_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  ssl_pkg::bundle_t pop_data;

  ssl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ssl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ssl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (res)
  );

  `SSL_ASSERT(a_head_count, pop_valid |-> (pop_data.count != 3'd0 && pop_data.count <= ssl_pkg::MAX_COUNT), "queued bundle has a bad result count")
  `SSL_ASSERT(a_done_last, (res.valid && res.kind == ssl_pkg::KIND_DONE) |-> res.run_end, "source done is not the last result of its byte")
  `SSL_ASSERT(a_error_alone, (res.valid && (res.kind == ssl_pkg::KIND_UNTERM_STRING || res.kind == ssl_pkg::KIND_UNTERM_ESCAPE)) |-> res.run_end, "error result is not the last of its byte")
  `SSL_ASSERT(a_value_zero, (res.valid && res.kind != ssl_pkg::KIND_BYTE) |-> (res.value_out == 8'd0), "non-byte result carries a value")

endmodule

>>> tb/tb_script_source_lexer_core.sv
`timescale 1ns / 100ps

module tb_script_source_lexer_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 255;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] value;
    logic       run_end;
  } lex_result_t;

  logic clk = 1'b0;
  logic rst;

  ssl_in_if  src_if ();
  ssl_out_if res_if ();

  script_source_lexer_core i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .res (res_if)
  );

  // Results still owed by the block, oldest first.
  lex_result_t expected_results[$];
  // Results of the byte being predicted.
  lex_result_t byte_results[$];

  logic [2:0] lex_mode;
  bit         token_open;
  bit         line_open;

  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] value);
    lex_result_t r;
    r.kind    = kind;
    r.value   = (kind == ssl_pkg::KIND_BYTE) ? value : 8'd0;
    r.run_end = 1'b0;
    byte_results = {byte_results, r};
  endfunction

  function automatic void add_token_byte(input logic [7:0] value);
    token_open = 1'b1;
    add_result(ssl_pkg::KIND_BYTE, value);
  endfunction

  function automatic void end_token();
    if (token_open) begin
      add_result(ssl_pkg::KIND_TOKEN_END, 8'd0);
      token_open = 1'b0;
      line_open  = 1'b1;
    end
  endfunction

  function automatic void end_at_delimiter(input logic [7:0] c);
    end_token();
    if (c == ssl_pkg::CH_LF) begin
      add_result(ssl_pkg::KIND_LINE_END, 8'd0);
      line_open = 1'b0;
    end
  endfunction

  function automatic void reset_lexer();
    lex_mode   = ssl_pkg::MODE_NORMAL;
    token_open = 1'b0;
    line_open  = 1'b0;
  endfunction

  // Advance the lexer state by one source byte and queue what it must emit.
  function automatic void lex_predict(input logic [7:0] c, input bit last);
    bit finish;
    finish = last;
    byte_results.delete();
    case (lex_mode)
      ssl_pkg::MODE_SKIP: begin
        finish = 1'b0;
      end
      ssl_pkg::MODE_STRING: begin
        if (c == ssl_pkg::CH_LF ||
            (last && c != ssl_pkg::CH_QUOTE && c != ssl_pkg::CH_BSLASH)) begin
          add_result(ssl_pkg::KIND_UNTERM_STRING, 8'd0);
          finish   = 1'b0;
          lex_mode = ssl_pkg::MODE_SKIP;
        end else if (c == ssl_pkg::CH_BSLASH) begin
          if (last) begin
            add_result(ssl_pkg::KIND_UNTERM_ESCAPE, 8'd0);
            finish   = 1'b0;
            lex_mode = ssl_pkg::MODE_SKIP;
          end else begin
            lex_mode = ssl_pkg::MODE_ESCAPE;
          end
        end else begin
          add_token_byte(c);
          if (c == ssl_pkg::CH_QUOTE) lex_mode = ssl_pkg::MODE_NORMAL;
        end
      end
      ssl_pkg::MODE_ESCAPE: begin
        if (last) begin
          add_result(ssl_pkg::KIND_UNTERM_STRING, 8'd0);
          finish   = 1'b0;
          lex_mode = ssl_pkg::MODE_SKIP;
        end else begin
          case (c)
            ssl_pkg::CH_N:     add_token_byte(ssl_pkg::CH_LF);
            ssl_pkg::CH_B:     add_token_byte(ssl_pkg::CH_BS);
            ssl_pkg::CH_T:     add_token_byte(ssl_pkg::CH_TAB);
            ssl_pkg::CH_QUOTE: add_token_byte(ssl_pkg::CH_QUOTE);
            default: begin
              add_token_byte(ssl_pkg::CH_BSLASH);
              add_token_byte(c);
            end
          endcase
          lex_mode = ssl_pkg::MODE_STRING;
        end
      end
      ssl_pkg::MODE_COMMENT: begin
        if (c == ssl_pkg::CH_LF) begin
          end_at_delimiter(c);
          lex_mode = ssl_pkg::MODE_NORMAL;
        end
      end
      default: begin
        lex_mode = ssl_pkg::MODE_NORMAL;
        if (c == ssl_pkg::CH_LF || c == ssl_pkg::CH_CR || c == ssl_pkg::CH_SPACE) begin
          end_at_delimiter(c);
        end else if (c == ssl_pkg::CH_QUOTE) begin
          if (last) begin
            add_result(ssl_pkg::KIND_UNTERM_STRING, 8'd0);
            finish   = 1'b0;
            lex_mode = ssl_pkg::MODE_SKIP;
          end else begin
            add_token_byte(c);
            lex_mode = ssl_pkg::MODE_STRING;
          end
        end else if (c == ssl_pkg::CH_SLASH) begin
          lex_mode = ssl_pkg::MODE_COMMENT;
        end else begin
          add_token_byte(c);
        end
      end
    endcase

    if (finish) begin
      end_token();
      if (line_open) add_result(ssl_pkg::KIND_LINE_END, 8'd0);
      add_result(ssl_pkg::KIND_DONE, 8'd0);
      reset_lexer();
    end else if (last) begin
      reset_lexer();
    end

    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
    foreach (byte_results[i]) expected_results = {expected_results, byte_results[i]};
  endfunction

  task automatic send_byte(input logic [7:0] c, input bit last);
    int gap;
    gap = 0;
    if (source_gaps && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid         <= 1'b1;
    src_if.code_in       <= c;
    src_if.end_of_source <= last;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    lex_predict(c, last);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && (i == s.len() - 1));
  endtask

  task automatic wait_for_results();
    src_if.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_special();
    logic [7:0] specials[9];
    specials = '{ssl_pkg::CH_LF, ssl_pkg::CH_CR, ssl_pkg::CH_SPACE, ssl_pkg::CH_QUOTE,
                 ssl_pkg::CH_BSLASH, ssl_pkg::CH_SLASH, ssl_pkg::CH_N, ssl_pkg::CH_B,
                 ssl_pkg::CH_T};
    return specials[$urandom_range(0, 8)];
  endfunction

  // Any byte that does not end a token or open a string or comment.
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ssl_pkg::CH_LF || c == ssl_pkg::CH_CR || c == ssl_pkg::CH_SPACE ||
           c == ssl_pkg::CH_QUOTE || c == ssl_pkg::CH_SLASH);
    return c;
  endfunction

  // One source text: well formed, cut short, or plain noise.
  task automatic send_random_source();
    logic [7:0] text[$];
    logic [7:0] c;
    int shape;
    int pieces;
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      repeat ($urandom_range(1, 8)) begin
        text = {text, ($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)))};
      end
    end else begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
        case ($urandom_range(0, 6))
          0, 1: repeat ($urandom_range(1, 4)) text = {text, pick_plain()};
          2: begin
            text = {text, ssl_pkg::CH_QUOTE};
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(0, 3))
                0: text = {text, ssl_pkg::CH_SPACE};
                1: begin
                  text = {text, ssl_pkg::CH_BSLASH};
                  text = {text, ($urandom_range(0, 1) ? pick_special()
                                                      : 8'($urandom_range(0, 255)))};
                end
                default: begin
                  do c = 8'($urandom_range(0, 255));
                  while (c == ssl_pkg::CH_LF || c == ssl_pkg::CH_QUOTE ||
                         c == ssl_pkg::CH_BSLASH);
                  text = {text, c};
                end
              endcase
            end
            text = {text, ssl_pkg::CH_QUOTE};
          end
          3: text = {text, ssl_pkg::CH_SPACE};
          4: text = {text, ssl_pkg::CH_CR};
          5: text = {text, ssl_pkg::CH_LF};
          default: begin
            text = {text, ssl_pkg::CH_SLASH};
            repeat ($urandom_range(0, 3)) begin
              do c = 8'($urandom_range(0, 255));
              while (c == ssl_pkg::CH_LF);
              text = {text, c};
            end
            text = {text, ssl_pkg::CH_LF};
          end
        endcase
      end
      // Cut some sources short so the end can land mid-string or mid-escape.
      if (shape < 30) begin
        while (text.size() > 1 && $urandom_range(0, 2) != 0) text = text[0:$-1];
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic test_directed();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    // Extreme bytes run straight into a string with every escape and a space.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("'\\n\\b\\t\\' \\\n'", 1'b0);
    // CR ends the token, comment to LF, then an empty line.
    send_byte(ssl_pkg::CH_CR, 1'b0);
    send_text("/x\n\n", 1'b0);
    // Opening quote as the last byte.
    send_text("'", 1'b1);
    // Backslash as the last byte inside a string.
    send_text("'\\", 1'b1);
    // Escape character as the last byte, reported as an unterminated string.
    send_text("'\\n", 1'b1);
    // LF inside a string, then skip to the end of source.
    send_text("'a\nb", 1'b1);
  endtask

  task automatic test_back_to_back();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (8) send_random_source();
  endtask

  task automatic test_drain_pause();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_text("ab 'c", 1'b0);
    wait_for_results();
    send_text("d' e", 1'b1);
  endtask

  task automatic test_random_traffic();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        source_gaps = !source_gaps;
        sink_stalls = 1'($urandom_range(0, 1));
      end
      send_random_source();
    end
  endtask

  // Result sink: random stalls while enabled.
  initial begin
    int hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else if (!sink_stalls || $urandom_range(0, 3) != 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        hold = pick_gap() - 1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  initial begin
    lex_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d value %0h run_end %0b", $time,
                   res_if.kind, res_if.value_out, res_if.run_end);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind,
                     res_if.kind);
            error_count++;
          end
          if (res_if.value_out !== want.value) begin
            $display("%0t: value_out mismatch, expected %0h, got %0h", $time, want.value,
                     res_if.value_out);
            error_count++;
          end
          if (res_if.run_end !== want.run_end) begin
            $display("%0t: run_end mismatch, expected %0b, got %0b", $time, want.run_end,
                     res_if.run_end);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
    $display("FAIL script_source_lexer_core");
    $finish;
  end

  initial begin
    rst                  <= 1'b1;
    src_if.valid         <= 1'b0;
    src_if.code_in       <= 8'd0;
    src_if.end_of_source <= 1'b0;
    reset_lexer();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS script_source_lexer_core");
    end else begin
      $display("FAIL script_source_lexer_core");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_if.sv
hw/rtl/ssl_front.sv
hw/rtl/ssl_fifo.sv
hw/rtl/ssl_back.sv
hw/rtl/script_source_lexer_core.sv
tb/tb_script_source_lexer_core.sv
